### sv/work_flag_rmw_unit_core_defines.svh
// Assertion macros for the work and flag read-modify-write unit
`ifndef WORK_FLAG_RMW_UNIT_CORE_DEFINES_SVH
`define WORK_FLAG_RMW_UNIT_CORE_DEFINES_SVH

// implication in the same cycle, sampled on clk, off while arst_n is low
`define WFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// implication into the next cycle
`define WFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### sv/wfr_pkg.sv
// Types and constants shared by the work and flag read-modify-write unit
`timescale 1ns / 1ps
package wfr_pkg;

	localparam logic [7:0] OP_ASSIGN = 8'h25;
	localparam logic [7:0] OP_MUL    = 8'h26;
	localparam logic [7:0] OP_DIV    = 8'h27;
	localparam logic [7:0] OP_MOD    = 8'h28;
	localparam logic [7:0] OP_ADD    = 8'h29;
	localparam logic [7:0] OP_SUB    = 8'h2A;
	localparam logic [7:0] OP_AND    = 8'h2B;
	localparam logic [7:0] OP_XOR    = 8'h2C;
	localparam logic [7:0] OP_OR     = 8'h2D;
	localparam logic [7:0] OP_INC    = 8'h2E;
	localparam logic [7:0] OP_DEC    = 8'h2F;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_BAD_OP   = 2'd2;

	localparam logic FUNC_READ = 1'b0;
	localparam logic FUNC_RMW  = 1'b1;

	typedef struct packed {
		logic        func;
		logic        target_flags;
		logic [31:0] index;
		logic [31:0] operand;
		logic [7:0]  operation;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_WB
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic exec;
		logic wb;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

### sv/work_flag_rmw_unit_core.sv
// Top level of the work word and flag byte read-modify-write unit
// Request channel: req_valid / req_stall with payload req (func, target_flags,
// index, operand, operation). Response channel: rsp_valid / rsp_stall with
// payload rsp (value, status). A transfer happens when valid is high and
// stall is low at a rising edge of clk.
// Each request gives exactly one response. A request is taken in the idle
// state, then the entry is read from synchronous memory, the ALU runs and the
// result is written back and loaded into the response register.
// Signed divide and modulo with a nonzero divisor also pass through the
// bit-serial divider. The one-item-at-a-time sequencer takes no new request
// until the last one has been written back.
// Reset (arst_n low) clears the controller and the response valid flag. After
// reset a clearing pass zeroes both memories, one entry a cycle, while
// req_stall stays high.
// When the receiver stalls, the response holds and the next result waits in
// write-back; a new request may be taken while a response is still pending.
`timescale 1ns / 1ps
module work_flag_rmw_unit_core #(
	parameter int WORK_DEPTH = 128,
	parameter int FLAG_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  wfr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output wfr_pkg::rsp_t rsp
);

	wfr_pkg::ctrl_cmd_t cmd;
	wfr_pkg::dp_stat_t  stat;

	wfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	wfr_datapath #(
		.WORK_DEPTH (WORK_DEPTH),
		.FLAG_DEPTH (FLAG_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### sv/wfr_div.sv
// Iterative unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wfr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign done    = busy_q && (cnt_q == 5'd31);
	assign quo     = quo_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 32'd0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

### sv/wfr_datapath.sv
// Datapath: both memories, request capture, ALU, divider and result register
`timescale 1ns / 1ps
module wfr_datapath #(
	parameter int WORK_DEPTH = 128,
	parameter int FLAG_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wfr_pkg::ctrl_cmd_t  cmd,
	output wfr_pkg::dp_stat_t   stat,
	input  wfr_pkg::req_t       req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output wfr_pkg::rsp_t       rsp
);

	localparam int MAXD = (WORK_DEPTH > FLAG_DEPTH) ? WORK_DEPTH : FLAG_DEPTH;
	localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int WA   = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;
	localparam int FA   = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

	logic [31:0] work_mem [WORK_DEPTH];
	logic [7:0]  flag_mem [FLAG_DEPTH];

	wfr_pkg::req_t req_q;
	logic [CW-1:0] clr_q;
	logic [31:0]   work_rd_q;
	logic [7:0]    flag_rd_q;
	logic [31:0]   result_q;
	logic [1:0]    status_q;
	logic          is_div_q;
	logic          rsp_valid_q;
	wfr_pkg::rsp_t rsp_q;

	logic          in_range;
	logic [WA-1:0] work_addr;
	logic [FA-1:0] flag_addr;
	logic [31:0]   old;
	logic [31:0]   mag_a;
	logic [31:0]   mag_b;
	logic          div_op;
	logic          div_start;
	logic          div_done;
	logic [31:0]   div_quo;
	logic [31:0]   div_rem;
	logic [31:0]   div_val;
	logic [31:0]   final_val;
	logic          do_write;

	assign in_range = req_q.target_flags
		? (!req_q.index[31] && ({3'b000, req_q.index[31:3]} < 32'(FLAG_DEPTH)))
		: (req_q.index < 32'(WORK_DEPTH));
	assign work_addr = req_q.index[WA-1:0];
	assign flag_addr = req_q.index[FA+2:3];
	assign old = !in_range ? 32'd0
		: (req_q.target_flags ? {24'd0, flag_rd_q} : work_rd_q);
	assign mag_a = old[31] ? (32'd0 - old) : old;
	assign mag_b = req_q.operand[31] ? (32'd0 - req_q.operand) : req_q.operand;
	assign div_op = (req_q.operation == wfr_pkg::OP_DIV) ||
		(req_q.operation == wfr_pkg::OP_MOD);
	assign div_start = cmd.exec && (req_q.func == wfr_pkg::FUNC_RMW) && div_op &&
		(req_q.operand != 32'd0);

	wfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		if (req_q.operation == wfr_pkg::OP_MOD) begin
			div_val = old[31] ? (32'd0 - div_rem) : div_rem;
		end else begin
			div_val = (old[31] != req_q.operand[31]) ? (32'd0 - div_quo) : div_quo;
		end
		final_val = is_div_q ? div_val : result_q;
		if (status_q != wfr_pkg::ST_OK) begin
			final_val = 32'd0;
		end
	end

	assign do_write = cmd.wb && (req_q.func == wfr_pkg::FUNC_RMW) &&
		(status_q == wfr_pkg::ST_OK) && in_range;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		work_rd_q <= work_mem[work_addr];
		flag_rd_q <= flag_mem[flag_addr];
		if (cmd.clr) begin
			if (32'(clr_q) < 32'(WORK_DEPTH)) begin
				work_mem[clr_q[WA-1:0]] <= 32'd0;
			end
			if (32'(clr_q) < 32'(FLAG_DEPTH)) begin
				flag_mem[clr_q[FA-1:0]] <= 8'd0;
			end
		end else if (do_write) begin
			if (req_q.target_flags) begin
				flag_mem[flag_addr] <= final_val[7:0];
			end else begin
				work_mem[work_addr] <= final_val;
			end
		end
		if (cmd.wb) begin
			rsp_q.value  <= final_val;
			rsp_q.status <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= wfr_pkg::ST_OK;
			is_div_q <= 1'b0;
			result_q <= old;
			if (req_q.func == wfr_pkg::FUNC_RMW) begin
				case (req_q.operation)
					wfr_pkg::OP_ASSIGN: result_q <= req_q.operand;
					wfr_pkg::OP_MUL:    result_q <= old * req_q.operand;
					wfr_pkg::OP_DIV, wfr_pkg::OP_MOD: begin
						is_div_q <= 1'b1;
						if (req_q.operand == 32'd0) begin
							status_q <= wfr_pkg::ST_DIV_ZERO;
						end
					end
					wfr_pkg::OP_ADD:    result_q <= old + req_q.operand;
					wfr_pkg::OP_SUB:    result_q <= old - req_q.operand;
					wfr_pkg::OP_AND:    result_q <= old & req_q.operand;
					wfr_pkg::OP_XOR:    result_q <= old ^ req_q.operand;
					wfr_pkg::OP_OR:     result_q <= old | req_q.operand;
					wfr_pkg::OP_INC:    result_q <= old + 32'd1;
					wfr_pkg::OP_DEC:    result_q <= old - 32'd1;
					default:            status_q <= wfr_pkg::ST_BAD_OP;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd.wb) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.clr_last = (32'(clr_q) == 32'(MAXD - 1));
	assign stat.need_div = div_start;
	assign stat.div_done = div_done;
	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

### sv/wfr_ctrl.sv
// Controller state machine sequencing clear, read, execute, divide and write-back
`timescale 1ns / 1ps
module wfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  wfr_pkg::dp_stat_t  stat,
	output wfr_pkg::ctrl_cmd_t cmd
);

	wfr_pkg::state_t state_q;
	wfr_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfr_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			wfr_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = wfr_pkg::S_IDLE;
				end
			end
			wfr_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = wfr_pkg::S_READ;
				end
			end
			wfr_pkg::S_READ: begin
				state_nxt = wfr_pkg::S_EXEC;
			end
			wfr_pkg::S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = stat.need_div ? wfr_pkg::S_DIV : wfr_pkg::S_WB;
			end
			wfr_pkg::S_DIV: begin
				if (stat.div_done) begin
					state_nxt = wfr_pkg::S_WB;
				end
			end
			wfr_pkg::S_WB: begin
				if (stat.out_free) begin
					cmd.wb    = 1'b1;
					state_nxt = wfr_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = wfr_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/wfr_checker.sv
// Port checker for the read-modify-write unit and its bind
`timescale 1ns / 1ps
`include "work_flag_rmw_unit_core_defines.svh"
module wfr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input wfr_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input wfr_pkg::rsp_t rsp
);

	`WFR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`WFR_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)
	`WFR_ASSERT_IMP(a_status_code, rsp_valid, (rsp.status == wfr_pkg::ST_OK) || (rsp.status == wfr_pkg::ST_DIV_ZERO) || (rsp.status == wfr_pkg::ST_BAD_OP))
	`WFR_ASSERT_IMP(a_err_zero, rsp_valid && (rsp.status != wfr_pkg::ST_OK), rsp.value == 32'd0)

endmodule

bind work_flag_rmw_unit_core wfr_checker u_wfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/testbench.sv
// Self-checking testbench for the work word and flag byte read-modify-write unit
`timescale 1ns / 1ps
module testbench;

	localparam int WORK_DEPTH = 128;
	localparam int FLAG_DEPTH = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] OP_UNKNOWN = 8'h36;
	localparam logic [7:0] OP_ZERO    = 8'h00;
	localparam logic [7:0] OP_TOP     = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	wfr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	wfr_pkg::rsp_t rsp;

	logic [31:0] work_mem [WORK_DEPTH];
	logic [7:0] flag_mem [FLAG_DEPTH];
	wfr_pkg::rsp_t expected_rsps [$];
	int errors = 0;
	int cycles = 0;
	bit rsp_hold = 1'b0;
	bit no_idle = 1'b0;

	work_flag_rmw_unit_core #(.WORK_DEPTH(WORK_DEPTH), .FLAG_DEPTH(FLAG_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [31:0] neg(input logic [31:0] x);
		return ~x + 32'd1;
	endfunction

	function automatic wfr_pkg::rsp_t rmw_result(input wfr_pkg::req_t r);
		wfr_pkg::rsp_t o;
		logic [31:0] slot, v, ma, mb, q, rm;
		logic ok;
		o = '0;
		slot = r.target_flags ? (r.index >> 3) : r.index;
		ok = r.target_flags ? (!r.index[31] && slot < FLAG_DEPTH) : (slot < WORK_DEPTH);
		v = 32'd0;
		if (ok) v = r.target_flags ? {24'd0, flag_mem[slot]} : work_mem[slot];
		if (r.func == wfr_pkg::FUNC_READ) begin
			o.value = v;
			return o;
		end
		case (r.operation)
			wfr_pkg::OP_ASSIGN: v = r.operand;
			wfr_pkg::OP_MUL: v = v * r.operand;
			wfr_pkg::OP_DIV, wfr_pkg::OP_MOD: begin
				if (r.operand == 32'd0) begin
					o.status = wfr_pkg::ST_DIV_ZERO;
					return o;
				end
				ma = v[31] ? neg(v) : v;
				mb = r.operand[31] ? neg(r.operand) : r.operand;
				q = ma / mb;
				rm = ma % mb;
				if (r.operation == wfr_pkg::OP_MOD) v = v[31] ? neg(rm) : rm;
				else v = (v[31] != r.operand[31]) ? neg(q) : q;
			end
			wfr_pkg::OP_ADD: v = v + r.operand;
			wfr_pkg::OP_SUB: v = v - r.operand;
			wfr_pkg::OP_AND: v = v & r.operand;
			wfr_pkg::OP_XOR: v = v ^ r.operand;
			wfr_pkg::OP_OR: v = v | r.operand;
			wfr_pkg::OP_INC: v = v + 32'd1;
			wfr_pkg::OP_DEC: v = v - 32'd1;
			default: begin
				o.status = wfr_pkg::ST_BAD_OP;
				return o;
			end
		endcase
		if (ok) begin
			if (r.target_flags) flag_mem[slot] = v[7:0];
			else work_mem[slot] = v;
		end
		o.value = v;
		return o;
	endfunction

	task automatic send_req(input wfr_pkg::req_t r);
		while (!no_idle && $urandom_range(99) < 33) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_rsps.insert(expected_rsps.size(), rmw_result(r));
		@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_stall <= rsp_hold || (!no_idle && $urandom_range(99) < 33);

	always @(posedge clk) begin
		wfr_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response value=%h status=%0d", $time, rsp.value,
					rsp.status);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.value !== e.value) begin
					$display("%0t: value expected %h actual %h", $time, e.value, rsp.value);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						rsp.status);
					errors++;
				end
			end
		end
	end

	function automatic wfr_pkg::req_t mk(input logic f, input logic t, input logic [31:0] i,
		input logic [31:0] d, input logic [7:0] op);
		wfr_pkg::req_t r;
		r.func = f;
		r.target_flags = t;
		r.index = i;
		r.operand = d;
		r.operation = op;
		return r;
	endfunction

	function automatic logic [31:0] rand_index(input logic t);
		case ($urandom_range(9))
			0: return $urandom;
			1: return t ? 32'h8000_0000 | $urandom : 32'(WORK_DEPTH) + $urandom_range(3);
			default: return t ? $urandom_range(FLAG_DEPTH * 8 - 1) : $urandom_range(WORK_DEPTH - 1);
		endcase
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return $urandom_range(9);
			default: return $urandom;
		endcase
	endfunction

	function automatic wfr_pkg::req_t rand_req();
		logic t;
		logic [7:0] op;
		t = 1'($urandom_range(1));
		op = ($urandom_range(19) == 0) ? 8'($urandom)
			: 8'(wfr_pkg::OP_ASSIGN + $urandom_range(10));
		return mk($urandom_range(3) != 0, t, rand_index(t), rand_operand(), op);
	endfunction

	task automatic test_directed();
		send_req(mk(wfr_pkg::FUNC_READ, 1'b0, 32'd0, 32'hFFFF_FFFF, OP_TOP));
		send_req(mk(wfr_pkg::FUNC_READ, 1'b1, 32'hFFFF_FFFF, 32'd0, OP_ZERO));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd5, 32'h8000_0000, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd5, 32'hFFFF_FFFF, wfr_pkg::OP_DIV));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd6, 32'h8000_0000, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd6, 32'hFFFF_FFFF, wfr_pkg::OP_MOD));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd5, 32'd0, wfr_pkg::OP_DIV));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd5, 32'd0, wfr_pkg::OP_MOD));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd7, 32'hFFFF_FFF9, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd7, 32'd2, wfr_pkg::OP_MOD));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, 32'd7, 32'd3, wfr_pkg::OP_MUL));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH - 1, 32'hFFFF_FFFF, wfr_pkg::OP_ADD));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH - 1, 32'h1234_5678, wfr_pkg::OP_SUB));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH - 1, 32'hF0F0_F0F0, wfr_pkg::OP_AND));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH - 1, 32'hFFFF_0000, wfr_pkg::OP_XOR));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH - 1, 32'h0000_00FF, wfr_pkg::OP_OR));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b1, FLAG_DEPTH * 8 - 1, 32'd0, wfr_pkg::OP_DEC));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b1, FLAG_DEPTH * 8 - 1, 32'd0, wfr_pkg::OP_INC));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b1, 32'h8000_0008, 32'd9, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b0, WORK_DEPTH, 32'd9, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_READ, 1'b0, WORK_DEPTH, 32'd0, wfr_pkg::OP_ASSIGN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b1, 32'd8, 32'd1, OP_UNKNOWN));
		send_req(mk(wfr_pkg::FUNC_RMW, 1'b1, 32'd8, 32'd1, OP_ZERO));
		send_req(mk(wfr_pkg::FUNC_READ, 1'b1, 32'd15, 32'd0, wfr_pkg::OP_ASSIGN));
	endtask

	task automatic test_backpressure();
		fork
			begin
				rsp_hold = 1'b1;
				repeat (300) @(negedge clk);
				rsp_hold = 1'b0;
			end
			repeat (20) send_req(rand_req());
		join
	endtask

	task automatic test_random();
		repeat (400) send_req(rand_req());
		no_idle = 1'b1;
		repeat (200) send_req(rand_req());
		no_idle = 1'b0;
		repeat (400) send_req(rand_req());
	endtask

	initial begin
		foreach (work_mem[i]) work_mem[i] = '0;
		foreach (flag_mem[i]) flag_mem[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
